// ===== hw/rtl/sas_pkg.sv =====
package sas_pkg;

    // Table sizes and field widths of the sequencer.
    localparam int FRAMES          = 128;
    localparam int ANIMATIONS      = 16;
    localparam int FRAME_W         = $clog2(FRAMES);
    localparam int ANIM_W          = $clog2(ANIMATIONS);
    localparam int TEXEL_W         = 12;
    localparam int COORD_BITS      = 12;
    localparam int PERIOD_W        = 16;
    localparam int DELTA_W         = 16;
    localparam int INV_W           = 29;
    localparam int ACC_W           = 17;
    localparam int COORD_W         = 17;
    localparam int MODE_W          = 2;
    localparam int FUNC_W          = 2;
    localparam int PROD_W          = TEXEL_W + INV_W;
    localparam int FRAME_WORD_W    = 4 * TEXEL_W;
    localparam int ANIM_WORD_W     = 2 * FRAME_W + MODE_W;
    localparam int MAX_ADVANCE_DEF = 8;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = INV_W;

    // Reset values and limits.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
    localparam logic [INV_W-1:0]    INV_RESET    = 29'd65536;
    localparam logic [COORD_W-1:0]  COORD_ONE    = 17'd65536;
    localparam logic [ACC_W-1:0]    ACC_MAX      = 17'h1FFFF;

    // Item kinds carried in the slave-side tuser.
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WFRAME = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WANIM  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd3;

    // Animation play modes.
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_W   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_H   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLAYING = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_delta;
        logic wr_frame;
        logic wr_anim;
        logic rd_anim;
        logic load_anim;
        logic acc_add;
        logic advance;
        logic mul;
        logic emit;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_ge;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/sprite_animation_sequencer_unit.sv =====
// Sprite animation sequencer. Frame-write and animation-write items are
// taken in the idle state; a start item reads the animation table, then
// loads the current animation. A tick latches its time, adds it to the
// accumulator and tests the accumulator, then makes each frame advance:
// the frame step with the frame table read, the four coordinate
// multipliers, and the load of the output register, which waits while the
// result stream stalls. Up to MAX_ADVANCE advances are made per tick.
// The frame and animation tables are not cleared after reset and must be
// written before they are used.
module sprite_animation_sequencer_unit #(
    parameter int MAX_ADVANCE = sas_pkg::MAX_ADVANCE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // time_delta, frame_slot, anim_slot, rect_left, rect_top, rect_right,
    // rect_bottom, first_frame, final_frame, play_mode
    input  logic [sas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [sas_pkg::FUNC_W-1:0]        s_axis_tuser,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // shown_frame, u_left, u_right, v_low, v_high
    output logic [sas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    // behind
    output logic                              m_axis_tuser,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [sas_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sas_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    sas_pkg::t_cmd w_cmd;
    sas_pkg::t_sts w_sts;

    // Sequencing of items and advances.
    sas_ctrl #(
        .MAX_ADVANCE (MAX_ADVANCE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_func   (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Tables, accumulator, coordinate arithmetic and output register.
    sas_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_tdata   (s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tlast  (m_axis_tlast),
        .o_out_tuser  (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/sas_ctrl.sv =====
module sas_ctrl #(
    parameter int MAX_ADVANCE = sas_pkg::MAX_ADVANCE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic [sas_pkg::FUNC_W-1:0] i_s_func,
    output logic                       o_s_tready,
    input  sas_pkg::t_sts              i_sts,
    output sas_pkg::t_cmd              o_cmd
);

    localparam int CNT_W = $clog2(MAX_ADVANCE + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ADVANCE - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_last     = (r_cnt == CNT_LAST) || !i_sts.acc_ge;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_s_tvalid) begin
                    unique case (i_s_func)
                        sas_pkg::FUNC_TICK: begin
                            o_cmd.latch_delta = 1'b1;
                            n_state           = S_ACC;
                        end
                        sas_pkg::FUNC_WFRAME: begin
                            o_cmd.wr_frame = 1'b1;
                        end
                        sas_pkg::FUNC_WANIM: begin
                            o_cmd.wr_anim = 1'b1;
                        end
                        sas_pkg::FUNC_START: begin
                            o_cmd.rd_anim = 1'b1;
                            n_state       = S_START;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_START: begin
                o_cmd.load_anim = 1'b1;
                n_state         = S_IDLE;
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                n_state = i_sts.acc_ge ? S_ADV : S_IDLE;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = w_last;
                    n_cnt      = r_cnt + 1'b1;
                    n_state    = w_last ? S_IDLE : S_ADV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and advance counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The advance count of one tick never passes the limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) |-> (r_cnt <= CNT_LAST))
        else $error("advance started beyond the per-tick limit");

    // The last permitted advance of a tick always returns to idle.
    a_limit_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.out_free && r_cnt == CNT_LAST) |=> (r_state == S_IDLE))
        else $error("tick did not end after its last permitted advance");

endmodule

// ===== hw/rtl/sas_datapath.sv =====
module sas_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sas_pkg::t_cmd                      i_cmd,
    output sas_pkg::t_sts                      o_sts,
    input  logic [sas_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  logic                               i_cfg_we,
    input  logic [sas_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sas_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_out_tready,
    output logic                               o_out_tvalid,
    output logic [sas_pkg::OUT_TDATA_W-1:0]    o_out_tdata,
    output logic                               o_out_tlast,
    output logic                               o_out_tuser
);

    localparam int SH_W = sas_pkg::PROD_W - sas_pkg::COORD_BITS;

    // Input item fields.
    logic [sas_pkg::DELTA_W-1:0] w_delta;
    logic [sas_pkg::FRAME_W-1:0] w_frame_slot;
    logic [sas_pkg::ANIM_W-1:0]  w_anim_slot;
    logic [sas_pkg::TEXEL_W-1:0] w_left, w_top, w_right, w_bottom;
    logic [sas_pkg::FRAME_W-1:0] w_first, w_final;
    logic [sas_pkg::MODE_W-1:0]  w_mode;

    assign w_delta      = i_in_tdata[15:0];
    assign w_frame_slot = i_in_tdata[22:16];
    assign w_anim_slot  = i_in_tdata[26:23];
    assign w_left       = i_in_tdata[38:27];
    assign w_top        = i_in_tdata[50:39];
    assign w_right      = i_in_tdata[62:51];
    assign w_bottom     = i_in_tdata[74:63];
    assign w_first      = i_in_tdata[81:75];
    assign w_final      = i_in_tdata[88:82];
    assign w_mode       = i_in_tdata[90:89];

    // Configuration registers.
    logic [sas_pkg::PERIOD_W-1:0] r_frame_period;
    logic [sas_pkg::INV_W-1:0]    r_inv_w;
    logic [sas_pkg::INV_W-1:0]    r_inv_h;
    logic                         r_playing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= sas_pkg::PERIOD_RESET;
            r_inv_w        <= sas_pkg::INV_RESET;
            r_inv_h        <= sas_pkg::INV_RESET;
            r_playing      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sas_pkg::CFG_PERIOD:  r_frame_period <= i_cfg_wdata[sas_pkg::PERIOD_W-1:0];
                sas_pkg::CFG_INV_W:   r_inv_w        <= i_cfg_wdata;
                sas_pkg::CFG_INV_H:   r_inv_h        <= i_cfg_wdata;
                sas_pkg::CFG_PLAYING: r_playing      <= i_cfg_wdata[0];
                default: begin
                    r_playing <= r_playing;
                end
            endcase
        end
    end

    // A zero period counts as one time unit.
    logic [sas_pkg::PERIOD_W-1:0] w_period;
    assign w_period = (r_frame_period == '0) ? sas_pkg::PERIOD_W'(1) : r_frame_period;

    // Frame and animation tables, read data registered.
    logic [sas_pkg::FRAME_WORD_W-1:0] r_frame_mem [sas_pkg::FRAMES];
    logic [sas_pkg::ANIM_WORD_W-1:0]  r_anim_mem  [sas_pkg::ANIMATIONS];
    logic [sas_pkg::FRAME_WORD_W-1:0] r_frame_rd;
    logic [sas_pkg::ANIM_WORD_W-1:0]  r_anim_rd;
    logic [sas_pkg::FRAME_W-1:0]      w_next_frame;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_frame) begin
            r_frame_mem[w_frame_slot] <= {w_bottom, w_right, w_top, w_left};
        end
        if (i_cmd.advance) begin
            r_frame_rd <= r_frame_mem[w_next_frame];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_anim) begin
            r_anim_mem[w_anim_slot] <= {w_mode, w_final, w_first};
        end
        if (i_cmd.rd_anim) begin
            r_anim_rd <= r_anim_mem[w_anim_slot];
        end
    end

    // Current animation, current frame and time accumulator.
    logic [sas_pkg::FRAME_W-1:0] r_anim_first, r_anim_final, r_cur_frame;
    logic [sas_pkg::MODE_W-1:0]  r_anim_mode;
    logic [sas_pkg::ACC_W-1:0]   r_acc;
    logic [sas_pkg::DELTA_W-1:0] r_delta;
    logic [sas_pkg::ACC_W:0]     w_sum;
    logic [sas_pkg::FRAME_W-1:0] w_inc;
    logic                        w_runs;

    assign w_sum  = {1'b0, r_acc} + (sas_pkg::ACC_W + 1)'(r_delta);
    assign w_runs = r_playing
                    && (r_anim_mode == sas_pkg::MODE_ONCE || r_anim_mode == sas_pkg::MODE_LOOP);
    assign w_inc  = r_cur_frame + 1'b1;

    // Next frame: wrap or hold once past the final frame.
    always_comb begin
        w_next_frame = w_inc;
        if (w_inc > r_anim_final) begin
            case (r_anim_mode)
                sas_pkg::MODE_ONCE: w_next_frame = r_anim_final;
                sas_pkg::MODE_LOOP: w_next_frame = r_anim_first;
                default:            w_next_frame = w_inc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_delta) begin
            r_delta <= w_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim_first <= '0;
            r_anim_final <= '0;
            r_anim_mode  <= sas_pkg::MODE_STOP;
            r_cur_frame  <= '0;
            r_acc        <= '0;
        end else begin
            if (i_cmd.load_anim) begin
                r_anim_first <= r_anim_rd[sas_pkg::FRAME_W-1:0];
                r_anim_final <= r_anim_rd[2*sas_pkg::FRAME_W-1:sas_pkg::FRAME_W];
                r_anim_mode  <= r_anim_rd[sas_pkg::ANIM_WORD_W-1:2*sas_pkg::FRAME_W];
                r_cur_frame  <= r_anim_rd[sas_pkg::FRAME_W-1:0];
            end
            if (i_cmd.acc_add && w_runs) begin
                r_acc <= w_sum[sas_pkg::ACC_W] ? sas_pkg::ACC_MAX
                                               : w_sum[sas_pkg::ACC_W-1:0];
            end
            if (i_cmd.advance) begin
                r_acc       <= r_acc - sas_pkg::ACC_W'(w_period);
                r_cur_frame <= w_next_frame;
            end
        end
    end

    assign o_sts.acc_ge = (r_acc >= sas_pkg::ACC_W'(w_period));

    // Texel times reciprocal, one multiplier per edge.
    logic [sas_pkg::PROD_W-1:0] r_prod_xl, r_prod_xr, r_prod_yl, r_prod_yh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_xl <= r_frame_rd[11:0]  * r_inv_w;
            r_prod_yl <= r_frame_rd[23:12] * r_inv_h;
            r_prod_xr <= r_frame_rd[35:24] * r_inv_w;
            r_prod_yh <= r_frame_rd[47:36] * r_inv_h;
        end
    end

    // Drop the fraction bits and clamp at 1.0.
    function automatic logic [sas_pkg::COORD_W-1:0] sat_coord(
        input logic [sas_pkg::PROD_W-1:0] prod
    );
        logic [SH_W-1:0] v;
        v = prod[sas_pkg::PROD_W-1:sas_pkg::COORD_BITS];
        if (v > SH_W'(sas_pkg::COORD_ONE)) begin
            return sas_pkg::COORD_ONE;
        end
        return v[sas_pkg::COORD_W-1:0];
    endfunction

    // Output register; the next advance proceeds while a result waits.
    logic                          r_out_valid;
    logic [sas_pkg::FRAME_W-1:0]   r_out_frame;
    logic [sas_pkg::COORD_W-1:0]   r_u_left, r_u_right, r_v_low, r_v_high;
    logic                          r_out_last, r_out_behind;

    assign o_sts.out_free = !r_out_valid || i_out_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_frame  <= r_cur_frame;
            r_u_left     <= sat_coord(r_prod_xl);
            r_u_right    <= sat_coord(r_prod_xr);
            r_v_low      <= sat_coord(r_prod_yl);
            r_v_high     <= sat_coord(r_prod_yh);
            r_out_last   <= i_cmd.last;
            r_out_behind <= i_cmd.last && o_sts.acc_ge;
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = {5'b0, r_v_high, r_v_low, r_u_right, r_u_left, r_out_frame};
    assign o_out_tlast  = r_out_last;
    assign o_out_tuser  = r_out_behind;

    // An advance is only commanded while a whole period is held.
    a_adv_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> o_sts.acc_ge)
        else $error("frame advance without a whole period in the accumulator");

    // A result is never loaded over one that has not been taken.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_tready))
        else $error("result overwritten before transfer");

endmodule
